/* rtl/catb_pkg.sv */
`default_nettype none

package catb_pkg;

	localparam int unsigned DEF_CLIENT_SLOTS = 16;
	localparam int unsigned DEF_OPCODE_SLOTS = 64;

	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned RATE_W   = 16;
	localparam int unsigned TOKEN_W  = 36;
	localparam int unsigned TIME_W   = 64;
	localparam int unsigned TRAIT_W  = RATE_W + 2;
	localparam int unsigned BUCKET_W = RATE_W + TOKEN_W + TIME_W;
	localparam int unsigned MICRO_W  = 20;
	localparam int unsigned STATUS_W = 3;

	localparam logic [MICRO_W-1:0] MICRO_PER_TOKEN = 20'd1000000;

	localparam logic [SIZE_W-1:0] MIN_PAYLOAD_RESET = 16'd2;
	localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RESET = 16'd4096;

	// register indexes on the configuration port
	localparam logic REG_MIN_PAYLOAD = 1'b0;
	localparam logic REG_MAX_PAYLOAD = 1'b1;

	// command codes
	localparam logic CMD_WRITE_TRAITS = 1'b0;
	localparam logic CMD_ADMIT        = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_BAD_ARGS     = 3'd1,
		ST_NOT_FOUND    = 3'd2,
		ST_AUTH_FAILED  = 3'd3,
		ST_RATE_LIMITED = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic out_load;
		logic out_sel_bucket;
		logic bucket_wr;
		logic clear_wr;
	} catb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_bucket;
	} catb_stat_t;

endpackage

`default_nettype wire

/* rtl/catb_if.sv */
`default_nettype none

interface catb_req_if import catb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic [3:0]          client_slot;
	logic [7:0]          opcode;
	logic                client_authenticated;
	logic [SIZE_W-1:0]   payload_size;
	logic [TIME_W-1:0]   now_us;
	logic                trait_registered;
	logic                trait_requires_auth;
	logic [RATE_W-1:0]   trait_rate;

	modport source (
		output valid, command, client_slot, opcode, client_authenticated, payload_size,
		       now_us, trait_registered, trait_requires_auth, trait_rate,
		input  ready
	);
	modport sink (
		input  valid, command, client_slot, opcode, client_authenticated, payload_size,
		       now_us, trait_registered, trait_requires_auth, trait_rate,
		output ready
	);
endinterface

interface catb_res_if import catb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                forward;

	modport source (output valid, status, forward, input ready);
	modport sink (input valid, status, forward, output ready);
endinterface

`default_nettype wire

/* rtl/catb_regs.sv */
`default_nettype none

module catb_regs import catb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic      [SIZE_W-1:0] min_payload_bytes,
	output logic      [SIZE_W-1:0] max_payload_bytes
);

	logic [SIZE_W-1:0] min_q;
	logic [SIZE_W-1:0] max_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_PAYLOAD_RESET;
			max_q <= MAX_PAYLOAD_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_MIN_PAYLOAD) begin
				min_q <= pwdata[SIZE_W-1:0];
			end else begin
				max_q <= pwdata[SIZE_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_MIN_PAYLOAD) begin
			prdata = {{(32-SIZE_W){1'b0}}, min_q};
		end else begin
			prdata = {{(32-SIZE_W){1'b0}}, max_q};
		end
	end

	assign min_payload_bytes = min_q;
	assign max_payload_bytes = max_q;

endmodule

`default_nettype wire

/* rtl/catb_ctrl.sv */
`default_nettype none

module catb_ctrl import catb_pkg::*; #(
	parameter int unsigned CLIENT_SLOTS = DEF_CLIENT_SLOTS,
	parameter int unsigned OPCODE_SLOTS = DEF_OPCODE_SLOTS,
	localparam int unsigned BUCKETS = CLIENT_SLOTS * OPCODE_SLOTS,
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            res_valid,
	input  wire logic       res_ready,
	input  wire catb_stat_t stat,
	output catb_cmd_t       cmd,
	output logic [BW-1:0]   clear_addr
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_REFILL,
		S_DECIDE
	} state_t;

	state_t        state_q;
	logic          out_valid_q;
	logic [BW-1:0] clear_addr_q;
	logic          out_free;

	assign out_free  = !out_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign clear_addr = clear_addr_q;

	always_comb begin
		cmd                = '0;
		cmd.accept         = req_valid && (state_q == S_IDLE);
		cmd.clear_wr       = (state_q == S_CLEAR);
		cmd.out_sel_bucket = (state_q == S_DECIDE);
		cmd.bucket_wr      = (state_q == S_DECIDE) && out_free;
		cmd.out_load       = ((state_q == S_CHECK) && !stat.needs_bucket && out_free) ||
		                     ((state_q == S_DECIDE) && out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			out_valid_q  <= 1'b0;
			clear_addr_q <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clear_addr_q <= clear_addr_q + BW'(1);
					if (clear_addr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.needs_bucket) begin
						state_q <= S_MUL;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					state_q <= S_REFILL;
				end
				S_REFILL: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/catb_dp.sv */
`default_nettype none

module catb_dp import catb_pkg::*; #(
	parameter int unsigned CLIENT_SLOTS = DEF_CLIENT_SLOTS,
	parameter int unsigned OPCODE_SLOTS = DEF_OPCODE_SLOTS,
	localparam int unsigned BUCKETS = CLIENT_SLOTS * OPCODE_SLOTS,
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
	localparam int unsigned TW = (OPCODE_SLOTS > 1) ? $clog2(OPCODE_SLOTS) : 1,
	localparam int unsigned SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire catb_cmd_t           cmd,
	input  wire logic [BW-1:0]       clear_addr,
	input  wire logic [SIZE_W-1:0]   min_payload_bytes,
	input  wire logic [SIZE_W-1:0]   max_payload_bytes,
	input  wire logic                command,
	input  wire logic [3:0]          client_slot,
	input  wire logic [7:0]          opcode,
	input  wire logic                client_authenticated,
	input  wire logic [SIZE_W-1:0]   payload_size,
	input  wire logic [TIME_W-1:0]   now_us,
	input  wire logic                trait_registered,
	input  wire logic                trait_requires_auth,
	input  wire logic [RATE_W-1:0]   trait_rate,
	output catb_stat_t               stat,
	output logic [STATUS_W-1:0]      status,
	output logic                     forward
);

	// stores
	logic [TRAIT_W-1:0]      trait_mem_q [OPCODE_SLOTS];
	logic [OPCODE_SLOTS-1:0] trait_vld_q;
	logic [BUCKET_W-1:0]     bucket_mem_q [BUCKETS];

	// slot wrap table, built at elaboration
	logic [SW-1:0] slot_tbl [16];
	for (genvar g = 0; g < 16; g++) begin : g_slot
		assign slot_tbl[g] = SW'(g % CLIENT_SLOTS);
	end

	// accept-time decode
	logic          op_ok;
	logic [TW-1:0] taddr;
	logic [BW-1:0] baddr;
	logic          size_bad;

	assign op_ok    = {1'b0, opcode} < 9'(OPCODE_SLOTS);
	assign taddr    = op_ok ? opcode[TW-1:0] : '0;
	assign baddr    = BW'(slot_tbl[client_slot]) * BW'(OPCODE_SLOTS) +
	                  (op_ok ? BW'(opcode) : '0);
	assign size_bad = (payload_size < min_payload_bytes) ||
	                  (payload_size > max_payload_bytes);

	// request registers
	logic                cmd_q;
	logic                auth_q;
	logic                size_bad_q;
	logic                op_bad_q;
	logic [TIME_W-1:0]   now_q;
	logic [TRAIT_W-1:0]  trait_rd_q;
	logic                trait_rd_vld_q;
	logic [BUCKET_W-1:0] bucket_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trait_vld_q <= '0;
		end else if (cmd.accept && command == CMD_WRITE_TRAITS && op_ok) begin
			trait_vld_q[taddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q          <= command;
			auth_q         <= client_authenticated;
			size_bad_q     <= size_bad;
			op_bad_q       <= !op_ok;
			now_q          <= now_us;
			trait_rd_q     <= trait_mem_q[taddr];
			trait_rd_vld_q <= trait_vld_q[taddr];
			bucket_rd_q    <= bucket_mem_q[baddr];
			if (command == CMD_WRITE_TRAITS && op_ok) begin
				trait_mem_q[taddr] <= {trait_rate, trait_requires_auth, trait_registered};
			end
		end
	end

	// check stage
	logic [TRAIT_W-1:0] tw;
	logic [RATE_W-1:0]  trate;
	logic [RATE_W-1:0]  b_rate;
	logic [TOKEN_W-1:0] b_tok;
	logic [TIME_W-1:0]  b_last;
	logic               created;
	logic [RATE_W-1:0]  eff_rate;
	logic [TOKEN_W-1:0] cap_c;
	logic [TIME_W-1:0]  elapsed;
	status_t            early_status;
	logic               early_fwd;

	assign tw       = trait_rd_vld_q ? trait_rd_q : '0;
	assign trate    = tw[TRAIT_W-1:2];
	assign b_rate   = bucket_rd_q[BUCKET_W-1 -: RATE_W];
	assign b_tok    = bucket_rd_q[TIME_W +: TOKEN_W];
	assign b_last   = bucket_rd_q[TIME_W-1:0];
	assign created  = (b_rate == '0);
	assign eff_rate = created ? trate : b_rate;
	assign cap_c    = TOKEN_W'(eff_rate) * TOKEN_W'(MICRO_PER_TOKEN);
	assign elapsed  = now_q - b_last;

	always_comb begin
		early_status      = ST_OK;
		early_fwd         = 1'b0;
		stat.needs_bucket = 1'b0;
		if (cmd_q == CMD_WRITE_TRAITS) begin
			early_status = ST_OK;
		end else if (size_bad_q) begin
			early_status = ST_BAD_ARGS;
		end else if (op_bad_q || !tw[0]) begin
			early_status = ST_NOT_FOUND;
		end else if (tw[1] && !auth_q) begin
			early_status = ST_AUTH_FAILED;
		end else if (trate == '0) begin
			early_fwd = 1'b1;
		end else begin
			stat.needs_bucket = 1'b1;
		end
	end

	// bucket stages; sources hold while the item is in flight
	logic [RATE_W-1:0]  rate_s2;
	logic [TOKEN_W-1:0] cap_s2;
	logic [TOKEN_W-1:0] tok_s2;
	logic               created_s2;
	logic               nz_s2;
	logic               ge_s2;
	logic [MICRO_W-1:0] elo_s2;

	logic [RATE_W-1:0]  rate_s3;
	logic [TOKEN_W-1:0] cap_s3;
	logic [TOKEN_W-1:0] tok_s3;
	logic [TOKEN_W-1:0] prod_s3;
	logic               nz_s3;
	logic               ge_s3;

	logic [RATE_W-1:0]  rate_s4;
	logic [TOKEN_W-1:0] refill_s4;

	logic [TOKEN_W:0]   sum_c;
	logic [TOKEN_W-1:0] refill_c;

	assign sum_c = {1'b0, tok_s3} + {1'b0, prod_s3};

	always_comb begin
		if (!nz_s3) begin
			refill_c = tok_s3;
		end else if (ge_s3 || (sum_c > {1'b0, cap_s3})) begin
			refill_c = cap_s3;
		end else begin
			refill_c = sum_c[TOKEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rate_s2    <= eff_rate;
		cap_s2     <= cap_c;
		tok_s2     <= b_tok;
		created_s2 <= created;
		nz_s2      <= !created && (elapsed != '0);
		ge_s2      <= elapsed >= TIME_W'(MICRO_PER_TOKEN);
		elo_s2     <= elapsed[MICRO_W-1:0];

		rate_s3    <= rate_s2;
		cap_s3     <= cap_s2;
		tok_s3     <= created_s2 ? cap_s2 : tok_s2;
		prod_s3    <= TOKEN_W'(elo_s2) * TOKEN_W'(rate_s2);
		nz_s3      <= nz_s2;
		ge_s3      <= ge_s2;

		rate_s4    <= rate_s3;
		refill_s4  <= refill_c;
	end

	// decide and write back
	logic               take_ok;
	logic [TOKEN_W-1:0] new_tok;
	logic [BW-1:0]      baddr_q;

	assign take_ok = refill_s4 >= TOKEN_W'(MICRO_PER_TOKEN);
	assign new_tok = take_ok ? refill_s4 - TOKEN_W'(MICRO_PER_TOKEN) : refill_s4;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			baddr_q <= baddr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			bucket_mem_q[clear_addr] <= '0;
		end else if (cmd.bucket_wr) begin
			bucket_mem_q[baddr_q] <= {rate_s4, new_tok, now_q};
		end
	end

	// result register
	status_t status_q;
	logic    forward_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_sel_bucket) begin
				status_q  <= take_ok ? ST_OK : ST_RATE_LIMITED;
				forward_q <= take_ok;
			end else begin
				status_q  <= early_status;
				forward_q <= early_fwd;
			end
		end
	end

	assign status  = status_q;
	assign forward = forward_q;

endmodule

`default_nettype wire

/* rtl/command_admission_token_bucket.sv */
`default_nettype none

// Command admission with per-client, per-opcode token bucket policing. An item on req is either
// a trait write (command 0: store registered / requires-auth / rate for one opcode) or an admit
// request (command 1) that is checked in order for payload size bounds, opcode range, opcode
// registered, auth requirement and finally a token bucket kept for the (client slot, opcode)
// pair, skipped when the rate is zero; one result item (status, forward) leaves on res for
// every item. Buckets are created full on first use with a capacity of one second's worth of
// tokens and refill by elapsed microseconds times rate, held as integer micro-tokens. One item
// is in flight at a time: trait writes and requests decided before the bucket load their
// result from the check state after accept; requests that reach the bucket load it from the
// decide state after the bucket steps (bucket memory read at accept, multiply of elapsed time
// by rate, refill add and clamp, then take-token and write-back). A stalled res holds the item
// in its last step, and req.ready returns once the result is in the output register. After
// reset a clearing pass over the bucket memory writes all CLIENT_SLOTS*OPCODE_SLOTS entries
// (1024 at the defaults) with req.ready low; the APB port (min_payload_bytes at 0x0,
// max_payload_bytes at 0x4) is writable throughout.
module command_admission_token_bucket import catb_pkg::*; #(
	parameter int unsigned CLIENT_SLOTS = DEF_CLIENT_SLOTS,
	parameter int unsigned OPCODE_SLOTS = DEF_OPCODE_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	catb_req_if.sink         req,
	catb_res_if.source       res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int unsigned BUCKETS = CLIENT_SLOTS * OPCODE_SLOTS;
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic [SIZE_W-1:0] min_payload_bytes;
	logic [SIZE_W-1:0] max_payload_bytes;
	catb_cmd_t         cmd;
	catb_stat_t        stat;
	logic [BW-1:0]     clear_addr;

	// configuration registers
	catb_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.min_payload_bytes (min_payload_bytes),
		.max_payload_bytes (max_payload_bytes)
	);

	// sequence the item: clear, accept, check, bucket steps, hand off to the output register
	catb_ctrl #(
		.CLIENT_SLOTS (CLIENT_SLOTS),
		.OPCODE_SLOTS (OPCODE_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.stat       (stat),
		.cmd        (cmd),
		.clear_addr (clear_addr)
	);

	// trait table, bucket memory and the refill arithmetic
	catb_dp #(
		.CLIENT_SLOTS (CLIENT_SLOTS),
		.OPCODE_SLOTS (OPCODE_SLOTS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.clear_addr           (clear_addr),
		.min_payload_bytes    (min_payload_bytes),
		.max_payload_bytes    (max_payload_bytes),
		.command              (req.command),
		.client_slot          (req.client_slot),
		.opcode               (req.opcode),
		.client_authenticated (req.client_authenticated),
		.payload_size         (req.payload_size),
		.now_us               (req.now_us),
		.trait_registered     (req.trait_registered),
		.trait_requires_auth  (req.trait_requires_auth),
		.trait_rate           (req.trait_rate),
		.stat                 (stat),
		.status               (res.status),
		.forward              (res.forward)
	);

	// a forwarded request always carries status ok
	a_fwd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.forward |-> res.status == ST_OK)
		else $error("forward set with non-ok status");

	// no item is taken while the bucket memory is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !req.ready)
		else $error("item accepted during clearing pass");

	// write-back never overlaps a new accept
	a_wb_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bucket_wr |-> !(req.valid && req.ready))
		else $error("bucket write-back collides with an accept");

	// one result per item: a result load is never followed directly by another
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !cmd.out_load)
		else $error("two results loaded back to back");

endmodule

`default_nettype wire
